### src/sts_pkg.sv
`default_nettype none

package sts_pkg;

	localparam int DEF_TABLE_DEPTH = 1024;
	localparam int DEF_VALUE_WIDTH = 32;

	localparam int MODE_W = 2;
	localparam int IDX_W  = 10;
	localparam int KEY_W  = 32;
	localparam int POS_W  = 11;

	localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_LOWER = 2'd1;
	localparam logic [MODE_W-1:0] MODE_WALK  = 2'd2;

	typedef struct packed {
		logic [POS_W-1:0] position;
		logic [KEY_W-1:0] entry_value;
		logic             past_end;
	} sts_res_t;

	// Width that holds any size or position up to and including the depth.
	function automatic int size_width(input int depth);
		int w;
		begin
			w = $clog2(depth + 1);
			return (w > POS_W) ? w : POS_W;
		end
	endfunction

endpackage

`default_nettype wire

### src/sts_engine.sv
`default_nettype none

module sts_engine
	import sts_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic [size_width(TABLE_DEPTH)-1:0]     used_size,
	input  wire logic                                   start,
	input  wire logic [MODE_W-1:0]                      mode,
	input  wire logic [IDX_W-1:0]                       index,
	input  wire logic [KEY_W-1:0]                       key,
	input  wire logic                                   out_free,
	output logic                                        busy,
	output logic                                        res_fire,
	output sts_res_t                                    res
);

	localparam int NW = size_width(TABLE_DEPTH);
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int RK = IDX_W + $clog2(TABLE_DEPTH);
	localparam int QW = 2 * IDX_W + 1;
	localparam longint RECIP = ((longint'(1) << RK) + longint'(TABLE_DEPTH) - 1)
		/ longint'(TABLE_DEPTH);

	localparam logic [2:0] S_IDLE     = 3'd0;
	localparam logic [2:0] S_WR       = 3'd1;
	localparam logic [2:0] S_LB       = 3'd2;
	localparam logic [2:0] S_LB_FIN   = 3'd3;
	localparam logic [2:0] S_WK_FIRST = 3'd4;
	localparam logic [2:0] S_WK_UP    = 3'd5;
	localparam logic [2:0] S_WK_DN    = 3'd6;
	localparam logic [2:0] S_DONE     = 3'd7;

	logic [VALUE_WIDTH-1:0] mem [TABLE_DEPTH];

	logic [2:0]             state_q, state_d;
	logic [NW-1:0]          base_q, base_d;
	logic [NW-1:0]          span_q, span_d;
	logic [VALUE_WIDTH-1:0] key_q, key_d;
	logic [IDX_W-1:0]       idx_q, idx_d;
	logic [IDX_W-1:0]       quot_q, quot_d;
	logic [VALUE_WIDTH-1:0] val_q, val_d;
	logic                   pe_q, pe_d;
	logic [VALUE_WIDTH-1:0] rdata_q;

	logic [NW-1:0]          raddr;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [QW-1:0]          quot_full, quot_back;
	logic [IDX_W-1:0]       quot_in, wr_rem;
	logic [NW-1:0]          half, probe, nb, ns, hint;
	logic [VALUE_WIDTH-1:0] cmp_a, cmp_b;
	logic                   cmp_lt;

	// The one signed comparator is shared by both searches.
	always_comb begin
		if (state_q == S_LB) begin
			cmp_a = rdata_q;
			cmp_b = key_q;
		end else begin
			cmp_a = key_q;
			cmp_b = rdata_q;
		end
		cmp_lt = $signed(cmp_a) < $signed(cmp_b);
	end

	// The write address is reduced modulo the depth by a reciprocal multiplication.
	always_comb begin
		quot_full = QW'(index) * QW'(RECIP);
		quot_in   = IDX_W'(quot_full >> RK);
		quot_back = QW'(quot_q) * QW'(TABLE_DEPTH);
		wr_rem    = idx_q - IDX_W'(quot_back);
		half  = span_q >> 1;
		probe = base_q + half;
		hint  = (NW'(index) < used_size) ? NW'(index) : used_size - NW'(1);
	end

	always_comb begin
		state_d  = state_q;
		base_d   = base_q;
		span_d   = span_q;
		key_d    = key_q;
		idx_d    = idx_q;
		quot_d   = quot_q;
		val_d    = val_q;
		pe_d     = pe_q;
		raddr    = base_q;
		we       = 1'b0;
		waddr    = AW'(wr_rem);
		nb       = base_q;
		ns       = half;
		res_fire = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					key_d = VALUE_WIDTH'($unsigned(key));
					unique case (mode)
						MODE_WRITE: begin
							idx_d   = index;
							quot_d  = quot_in;
							state_d = S_WR;
						end
						MODE_LOWER: begin
							base_d  = '0;
							span_d  = used_size;
							raddr   = used_size >> 1;
							state_d = S_LB;
						end
						MODE_WALK: begin
							base_d  = hint;
							raddr   = hint;
							pe_d    = 1'b0;
							state_d = S_WK_FIRST;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_WR: begin
				we      = 1'b1;
				state_d = S_IDLE;
			end
			S_LB: begin
				if (cmp_lt) begin
					nb = probe + NW'(1);
					ns = span_q - half - NW'(1);
				end
				base_d = nb;
				span_d = ns;
				if (ns == '0) begin
					raddr   = nb;
					state_d = S_LB_FIN;
				end else begin
					raddr = nb + (ns >> 1);
				end
			end
			S_LB_FIN: begin
				if (base_q < used_size) begin
					val_d = rdata_q;
					pe_d  = 1'b0;
				end else begin
					val_d = '0;
					pe_d  = 1'b1;
				end
				state_d = S_DONE;
			end
			S_WK_FIRST: begin
				val_d   = rdata_q;
				state_d = S_DONE;
				if (!cmp_lt) begin
					if (base_q + NW'(1) < used_size) begin
						raddr   = base_q + NW'(1);
						state_d = S_WK_UP;
					end
				end else if (base_q != '0) begin
					base_d  = base_q - NW'(1);
					raddr   = base_q - NW'(1);
					state_d = S_WK_DN;
				end
			end
			S_WK_UP: begin
				if (!cmp_lt) begin
					base_d = base_q + NW'(1);
					val_d  = rdata_q;
					if (base_q + NW'(2) < used_size) begin
						raddr = base_q + NW'(2);
					end else begin
						state_d = S_DONE;
					end
				end else begin
					state_d = S_DONE;
				end
			end
			S_WK_DN: begin
				if (!cmp_lt || base_q == '0) begin
					val_d   = rdata_q;
					state_d = S_DONE;
				end else begin
					base_d = base_q - NW'(1);
					raddr  = base_q - NW'(1);
				end
			end
			S_DONE: begin
				if (out_free) begin
					res_fire = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= key_q;
		end
		rdata_q <= mem[AW'(raddr)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		base_q <= base_d;
		span_q <= span_d;
		key_q  <= key_d;
		idx_q  <= idx_d;
		quot_q <= quot_d;
		val_q  <= val_d;
		pe_q   <= pe_d;
	end

	assign busy                = (state_q != S_IDLE);
	assign res.position        = base_q[POS_W-1:0];
	assign res.entry_value     = KEY_W'(val_q);
	assign res.past_end        = pe_q;

	a_lb_span: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LB |-> span_q != '0)
		else $error("lower bound step with empty span");

	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_WK_FIRST || state_q == S_WK_UP || state_q == S_WK_DN)
		|-> base_q < used_size)
		else $error("walk position beyond table size");

	a_wr_addr: assert property (@(posedge clk) disable iff (!arst_n)
		we |-> int'(wr_rem) < TABLE_DEPTH)
		else $error("write address beyond table depth");

	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_LB_FIN |=> state_q == S_DONE)
		else $error("lower bound finish did not reach result state");

endmodule

`default_nettype wire

### src/sorted_table_search.sv
// Table of signed values searched as if sorted ascending. Mode 0 writes key at index modulo
// the depth; mode 1 returns the lower bound of key (position equals the size and past_end is
// set when no entry is not less than key); mode 2 walks from the hint, clamped to the size,
// to the last entry not greater than key, or to entry 0. Mode 3 is dropped. The block takes
// one transaction at a time and holds in_stall while it works. A lower bound takes at most
// ceil(log2(size + 1)) halving steps, with one table read per step through the single
// memory read port. A walk reads the entry at the hint and then one entry per step beyond
// it. A search does not end while the result register is held by out_stall. Entries must
// be written before they are searched. Write table_size only while idle.
`default_nettype none

module sorted_table_search
	import sts_pkg::*;
#(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [POS_W-1:0]         cfg_wr_data,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [MODE_W-1:0]        mode,
	input  wire logic [IDX_W-1:0]         index,
	input  wire logic signed [KEY_W-1:0]  key,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic [POS_W-1:0]              position,
	output logic signed [KEY_W-1:0]       entry_value,
	output logic                          past_end
);

	localparam int NW = size_width(TABLE_DEPTH);

	logic [NW-1:0] table_size_q;
	logic [NW-1:0] used_size;
	logic          busy;
	logic          res_fire;
	logic          out_free;
	sts_res_t      res;
	logic          out_valid_q;
	sts_res_t      out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			table_size_q <= NW'(TABLE_DEPTH);
		end else if (cfg_wr_en) begin
			table_size_q <= NW'(cfg_wr_data);
		end
	end

	always_comb begin
		if (table_size_q == '0) begin
			used_size = NW'(1);
		end else if (table_size_q > NW'(TABLE_DEPTH)) begin
			used_size = NW'(TABLE_DEPTH);
		end else begin
			used_size = table_size_q;
		end
	end

	assign in_stall = busy;
	assign out_free = !out_valid_q || !out_stall;

	sts_engine #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.used_size (used_size),
		.start     (in_valid && !busy),
		.mode      (mode),
		.index     (index),
		.key       (key),
		.out_free  (out_free),
		.busy      (busy),
		.res_fire  (res_fire),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_fire) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign position    = out_q.position;
	assign entry_value = $signed(out_q.entry_value);
	assign past_end    = out_q.past_end;

endmodule

`default_nettype wire
